// ----- rtl/white_balance_gain_from_ratios_top_assert.svh -----
// Assertion macros for the white balance gain block.
// Depends on clk and rst_n being visible at the point of use.
`ifndef WHITE_BALANCE_GAIN_FROM_RATIOS_TOP_ASSERT_SVH
`define WHITE_BALANCE_GAIN_FROM_RATIOS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WBG_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("wbg assertion failed");
`define WBG_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("wbg assertion failed");
`else
`define WBG_ASSERT_IMPL(lbl, a, b)
`define WBG_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ----- rtl/wbg_pkg.sv -----
// Types and constants for the white balance gain block.
// No dependencies.
package wbg_pkg;

  localparam int unsigned DIV_BITS     = 32;
  localparam int unsigned UNITY_GAIN   = 1024;
  localparam int unsigned LIGHT_OFFSET = 512;
  localparam int unsigned GAIN_MAX     = 65535;
  localparam logic [9:0]  TYP_RG_RESET = 10'h138;
  localparam logic [9:0]  TYP_BG_RESET = 10'h127;

  typedef enum logic {
    REG_TYPICAL_RG = 1'b0,
    REG_TYPICAL_BG = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [9:0] red_ratio;
    logic [9:0] blue_ratio;
    logic [9:0] red_light;
    logic [9:0] blue_light;
  } in_t;

  typedef struct packed {
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    logic        red_write;
    logic        green_write;
    logic        blue_write;
    logic        gains_valid;
  } out_t;

  // Sideband that rides along the divider chains.
  typedef struct packed {
    logic [10:0] rg;
    logic [10:0] bg;
    logic [9:0]  trg;
    logic [9:0]  tbg;
    logic        bad;
    logic [20:0] g;
    logic        pin_r;
    logic        pin_b;
  } side_t;

  // One division lane: partial remainder, dividend/quotient shift word, divisor.
  typedef struct packed {
    logic [10:0]         rem;
    logic [DIV_BITS-1:0] acc;
    logic [10:0]         dsr;
  } lane_t;

  typedef struct packed {
    logic  valid;
    lane_t red;
    lane_t blue;
    side_t side;
  } stage_t;

endpackage

// ----- rtl/white_balance_gain_from_ratios_top.sv -----
// White balance gain block: top level with input, mid and output stages.
// Depends on wbg_pkg, wbg_div_chain and the assertion header.
`include "white_balance_gain_from_ratios_top_assert.svh"
//
// Usage:
//   Input channel: drive in_data and raise start; a transfer happens at each
//   clock edge with start high and busy low. busy stays low, so one
//   calibration set may be sent every cycle.
//   Result channel: out_valid strobes for one cycle with out_data; the
//   receiver must take it then, it cannot stall the block.
//   Configuration: cfg_we with cfg_index selects the typical R/G (0) or
//   B/G (1) ratio; write only while no transfer is in flight.
//   Pipeline: the light factor multiply is registered at the transfer edge
//   itself, then come 32 division cells, one register for the gain product
//   multiply, 32 more division cells and one output register.
//   Throughput: one item per cycle; each division cell retires one quotient
//   bit per cycle and hands its word to the next cell.
//   Reset: clears the valid bits along the chain and loads the typical
//   ratios 312 and 295; no result appears until an item is sent.
module white_balance_gain_from_ratios_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  wbg_pkg::in_t  in_data,
  output logic          out_valid,
  output wbg_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [9:0]    cfg_data
);

  // Configuration registers.
  logic [9:0] typ_rg_r;
  logic [9:0] typ_bg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      typ_rg_r <= wbg_pkg::TYP_RG_RESET;
      typ_bg_r <= wbg_pkg::TYP_BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wbg_pkg::REG_TYPICAL_RG: typ_rg_r <= cfg_data;
        wbg_pkg::REG_TYPICAL_BG: typ_bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input stage: apply the light factors, flag zero ratios.
  logic [20:0]    prod_rg;
  logic [20:0]    prod_bg;
  logic [10:0]    adj_rg;
  logic [10:0]    adj_bg;
  logic           s0_valid_r;
  wbg_pkg::side_t s0_side_r;
  wbg_pkg::side_t s0_side_nxt;

  always_comb begin
    prod_rg = 21'(in_data.red_ratio) *
              21'({1'b0, in_data.red_light} + 11'(wbg_pkg::LIGHT_OFFSET));
    prod_bg = 21'(in_data.blue_ratio) *
              21'({1'b0, in_data.blue_light} + 11'(wbg_pkg::LIGHT_OFFSET));
    adj_rg  = (in_data.red_light == '0) ? {1'b0, in_data.red_ratio} : prod_rg[20:10];
    adj_bg  = (in_data.blue_light == '0) ? {1'b0, in_data.blue_ratio} : prod_bg[20:10];
    s0_side_nxt       = '0;
    s0_side_nxt.rg    = adj_rg;
    s0_side_nxt.bg    = adj_bg;
    s0_side_nxt.trg   = typ_rg_r;
    s0_side_nxt.tbg   = typ_bg_r;
    s0_side_nxt.bad   = (in_data.red_ratio == '0) || (in_data.blue_ratio == '0) ||
                        (adj_rg == '0) || (adj_bg == '0) ||
                        (typ_rg_r == '0) || (typ_bg_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r <= s0_side_nxt;
  end

  // First chain: gr = 1024*rg/trg on the red lane, gb = 1024*bg/tbg on blue.
  wbg_pkg::stage_t c1_in;
  wbg_pkg::stage_t c1_out;

  always_comb begin
    c1_in.valid    = s0_valid_r;
    c1_in.red.rem  = '0;
    c1_in.red.acc  = wbg_pkg::DIV_BITS'({s0_side_r.rg, 10'b0});
    c1_in.red.dsr  = {1'b0, s0_side_r.trg};
    c1_in.blue.rem = '0;
    c1_in.blue.acc = wbg_pkg::DIV_BITS'({s0_side_r.bg, 10'b0});
    c1_in.blue.dsr = {1'b0, s0_side_r.tbg};
    c1_in.side     = s0_side_r;
  end

  wbg_div_chain u_chain1 (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (c1_in),
    .dout (c1_out)
  );

  // Mid stage: pick the quadrant, pin one channel, form g*typical products.
  logic [20:0]    gr;
  logic [20:0]    gb;
  logic [20:0]    g_sel;
  logic           pin_r;
  logic           pin_b;
  logic           s1_valid_r;
  wbg_pkg::side_t s1_side_r;
  logic [30:0]    s1_prod_r_r;
  logic [30:0]    s1_prod_b_r;
  wbg_pkg::side_t s1_side_nxt;

  always_comb begin
    gr    = c1_out.red.acc[20:0];
    gb    = c1_out.blue.acc[20:0];
    g_sel = 21'(wbg_pkg::UNITY_GAIN);
    pin_r = 1'b0;
    pin_b = 1'b0;
    if (c1_out.side.bg < {1'b0, c1_out.side.tbg}) begin
      if (c1_out.side.rg >= {1'b0, c1_out.side.trg}) begin
        g_sel = gr;
        pin_r = 1'b1;
      end
    end else begin
      if (c1_out.side.rg < {1'b0, c1_out.side.trg} || gb > gr) begin
        g_sel = gb;
        pin_b = 1'b1;
      end else begin
        g_sel = gr;
        pin_r = 1'b1;
      end
    end
    s1_side_nxt       = c1_out.side;
    s1_side_nxt.g     = g_sel;
    s1_side_nxt.pin_r = pin_r;
    s1_side_nxt.pin_b = pin_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= c1_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r   <= s1_side_nxt;
    s1_prod_r_r <= 31'(g_sel) * 31'(c1_out.side.trg);
    s1_prod_b_r <= 31'(g_sel) * 31'(c1_out.side.tbg);
  end

  // Second chain: r = g*trg/rg on red, b = g*tbg/bg on blue.
  wbg_pkg::stage_t c2_in;
  wbg_pkg::stage_t c2_out;

  always_comb begin
    c2_in.valid    = s1_valid_r;
    c2_in.red.rem  = '0;
    c2_in.red.acc  = wbg_pkg::DIV_BITS'(s1_prod_r_r);
    c2_in.red.dsr  = s1_side_r.rg;
    c2_in.blue.rem = '0;
    c2_in.blue.acc = wbg_pkg::DIV_BITS'(s1_prod_b_r);
    c2_in.blue.dsr = s1_side_r.bg;
    c2_in.side     = s1_side_r;
  end

  wbg_div_chain u_chain2 (
    .clk  (clk),
    .rst_n(rst_n),
    .din  (c2_in),
    .dout (c2_out)
  );

  // Output stage: drop the pinned quotient, saturate, set write flags; a flagged set gives all zeros.
  logic [wbg_pkg::DIV_BITS-1:0] r_full;
  logic [wbg_pkg::DIV_BITS-1:0] g_full;
  logic [wbg_pkg::DIV_BITS-1:0] b_full;
  logic                         out_valid_r;
  wbg_pkg::out_t                out_data_r;
  wbg_pkg::out_t                out_data_nxt;

  function automatic logic [15:0] sat16(input logic [wbg_pkg::DIV_BITS-1:0] v);
    return (v > wbg_pkg::DIV_BITS'(wbg_pkg::GAIN_MAX)) ? 16'hFFFF : v[15:0];
  endfunction

  always_comb begin
    r_full = c2_out.side.pin_r ? wbg_pkg::DIV_BITS'(wbg_pkg::UNITY_GAIN) : c2_out.red.acc;
    b_full = c2_out.side.pin_b ? wbg_pkg::DIV_BITS'(wbg_pkg::UNITY_GAIN) : c2_out.blue.acc;
    g_full = wbg_pkg::DIV_BITS'(c2_out.side.g);
    out_data_nxt = '0;
    if (!c2_out.side.bad) begin
      out_data_nxt.red_gain    = sat16(r_full);
      out_data_nxt.green_gain  = sat16(g_full);
      out_data_nxt.blue_gain   = sat16(b_full);
      out_data_nxt.red_write   = r_full > wbg_pkg::DIV_BITS'(wbg_pkg::UNITY_GAIN);
      out_data_nxt.green_write = g_full > wbg_pkg::DIV_BITS'(wbg_pkg::UNITY_GAIN);
      out_data_nxt.blue_write  = b_full > wbg_pkg::DIV_BITS'(wbg_pkg::UNITY_GAIN);
      out_data_nxt.gains_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c2_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An invalid result carries all-zero gains and flags.
  `WBG_ASSERT_IMPL(a_invalid_zero, out_valid && !out_data.gains_valid, out_data.red_gain == '0 && out_data.green_gain == '0 && out_data.blue_gain == '0 && !out_data.red_write && !out_data.green_write && !out_data.blue_write)
  // A valid result has one channel pinned at unity.
  `WBG_ASSERT_IMPL(a_one_pinned, out_valid && out_data.gains_valid, out_data.red_gain == 16'd1024 || out_data.green_gain == 16'd1024 || out_data.blue_gain == 16'd1024)
  // Red and blue write flags agree with the saturated gains.
  `WBG_ASSERT_IMPL(a_write_flag, out_valid, out_data.red_write == (out_data.red_gain > 16'd1024) && out_data.blue_write == (out_data.blue_gain > 16'd1024))
  // A valid mid-stage item reaches the second chain entry next cycle.
  `WBG_ASSERT_NEXT(a_mid_advance, c1_out.valid, s1_valid_r)

endmodule

// ----- rtl/wbg_div_cell.sv -----
// One restoring division cell: retires one quotient bit on both lanes.
// Depends on wbg_pkg.
module wbg_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  wbg_pkg::stage_t din,
  output wbg_pkg::stage_t dout
);

  function automatic wbg_pkg::lane_t step(input wbg_pkg::lane_t l);
    wbg_pkg::lane_t o;
    logic [11:0] tmp;
    logic [11:0] diff;
    logic        ge;
    tmp  = {l.rem, l.acc[wbg_pkg::DIV_BITS-1]};
    ge   = (tmp >= {1'b0, l.dsr});
    diff = tmp - {1'b0, l.dsr};
    o.rem = ge ? diff[10:0] : tmp[10:0];
    o.acc = {l.acc[wbg_pkg::DIV_BITS-2:0], ge};
    o.dsr = l.dsr;
    return o;
  endfunction

  logic           valid_r;
  wbg_pkg::lane_t red_r;
  wbg_pkg::lane_t blue_r;
  wbg_pkg::side_t side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    red_r  <= step(din.red);
    blue_r <= step(din.blue);
    side_r <= din.side;
  end

  assign dout = '{valid: valid_r, red: red_r, blue: blue_r, side: side_r};

endmodule

// ----- rtl/wbg_div_chain.sv -----
// Row of division cells, one per quotient bit.
// Depends on wbg_pkg and wbg_div_cell.
module wbg_div_chain (
  input  logic            clk,
  input  logic            rst_n,
  input  wbg_pkg::stage_t din,
  output wbg_pkg::stage_t dout
);

  wbg_pkg::stage_t link [wbg_pkg::DIV_BITS+1];

  assign link[0] = din;

  for (genvar i = 0; i < wbg_pkg::DIV_BITS; i++) begin : g_cell
    wbg_div_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[wbg_pkg::DIV_BITS];

endmodule

// ----- dv/tb_white_balance_gain_from_ratios_top.sv -----
// Testbench for the white balance gain block: directed and random calibration sets
// checked against a built-in gain predictor. Depends on wbg_pkg and the block's top level.
module tb_white_balance_gain_from_ratios_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 67;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  wbg_pkg::in_t      in_data;
  logic              out_valid;
  wbg_pkg::out_t     out_data;
  logic              cfg_we;
  wbg_pkg::reg_idx_t cfg_index;
  logic [9:0]        cfg_data;

  white_balance_gain_from_ratios_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copies of the typical ratio registers.
  logic [9:0] typ_rg;
  logic [9:0] typ_bg;

  wbg_pkg::in_t  pending_sets[$];
  wbg_pkg::out_t expected_gains[$];
  int            errors;

  // 10 ns high, 10 ns low.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned adjust_ratio(longint unsigned ratio,
                                                   longint unsigned light);
    if (light == 0) return ratio;
    return ratio * (light + wbg_pkg::LIGHT_OFFSET) / 1024;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > wbg_pkg::GAIN_MAX) ? 16'(wbg_pkg::GAIN_MAX) : 16'(v);
  endfunction

  // Compute the gains the block should produce for one calibration set.
  function automatic wbg_pkg::out_t compute_gains(wbg_pkg::in_t s, logic [9:0] trg_r,
                                                  logic [9:0] tbg_r);
    wbg_pkg::out_t   o;
    longint unsigned rg, bg, r, g, b, gr, gb, trg, tbg;
    trg = trg_r;
    tbg = tbg_r;
    o   = '0;
    rg  = adjust_ratio(s.red_ratio, s.red_light);
    bg  = adjust_ratio(s.blue_ratio, s.blue_light);
    // Any zero ratio, adjusted ratio or typical ratio: flag invalid, all zero.
    if (s.red_ratio == 0 || s.blue_ratio == 0 || rg == 0 || bg == 0 || trg == 0 || tbg == 0)
      return o;
    if (bg < tbg) begin
      if (rg < trg) begin
        g = wbg_pkg::UNITY_GAIN;
        b = wbg_pkg::UNITY_GAIN * tbg / bg;
        r = wbg_pkg::UNITY_GAIN * trg / rg;
      end else begin
        r = wbg_pkg::UNITY_GAIN;
        g = wbg_pkg::UNITY_GAIN * rg / trg;
        b = g * tbg / bg;
      end
    end else if (rg < trg) begin
      b = wbg_pkg::UNITY_GAIN;
      g = wbg_pkg::UNITY_GAIN * bg / tbg;
      r = g * trg / rg;
    end else begin
      gb = wbg_pkg::UNITY_GAIN * bg / tbg;
      gr = wbg_pkg::UNITY_GAIN * rg / trg;
      if (gb > gr) begin
        b = wbg_pkg::UNITY_GAIN;
        g = gb;
        r = g * trg / rg;
      end else begin
        r = wbg_pkg::UNITY_GAIN;
        g = gr;
        b = g * tbg / bg;
      end
    end
    o.red_gain    = clip16(r);
    o.green_gain  = clip16(g);
    o.blue_gain   = clip16(b);
    // Write flags look at the unclipped gains.
    o.red_write   = r > wbg_pkg::UNITY_GAIN;
    o.green_write = g > wbg_pkg::UNITY_GAIN;
    o.blue_write  = b > wbg_pkg::UNITY_GAIN;
    o.gains_valid = 1'b1;
    return o;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Driver: bursts of back-to-back transfers separated by random gaps.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_sets.size() != 0) begin
      start   <= 1'b1;
      in_data <= pending_sets[0];
      if (burst_left <= 1) begin
        // Close this burst; now and then follow it with a long unbroken stretch.
        burst_left <= ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
        gap_left   <= $urandom_range(0, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: take transfers and config writes into the predictor, check strobes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == wbg_pkg::REG_TYPICAL_RG) typ_rg <= cfg_data;
        else typ_bg <= cfg_data;
      end
      if (start && !busy) begin
        expected_gains.push_back(compute_gains(in_data, typ_rg, typ_bg));
        void'(pending_sets.pop_front());
      end
      if (out_valid) begin
        if (expected_gains.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, out_data);
          errors++;
        end else begin
          check_field("red_gain", expected_gains[0].red_gain, out_data.red_gain);
          check_field("green_gain", expected_gains[0].green_gain, out_data.green_gain);
          check_field("blue_gain", expected_gains[0].blue_gain, out_data.blue_gain);
          check_field("red_write", expected_gains[0].red_write, out_data.red_write);
          check_field("green_write", expected_gains[0].green_write, out_data.green_write);
          check_field("blue_write", expected_gains[0].blue_write, out_data.blue_write);
          check_field("gains_valid", expected_gains[0].gains_valid, out_data.gains_valid);
          void'(expected_gains.pop_front());
        end
      end
    end
  end

  function automatic wbg_pkg::in_t make_set(int rr, int br, int lr, int lb);
    wbg_pkg::in_t s;
    s.red_ratio  = 10'(rr);
    s.blue_ratio = 10'(br);
    s.red_light  = 10'(lr);
    s.blue_light = 10'(lb);
    return s;
  endfunction

  // Random set: mostly ratios near the typical values, some anywhere, some zero.
  function automatic wbg_pkg::in_t random_set();
    wbg_pkg::in_t s;
    int           mode;
    mode = $urandom_range(0, 9);
    s.red_ratio  = (mode < 6) ? 10'(int'(typ_rg) + $urandom_range(0, 120) - 60)
                              : 10'($urandom_range(0, 1023));
    s.blue_ratio = (mode < 6) ? 10'(int'(typ_bg) + $urandom_range(0, 120) - 60)
                              : 10'($urandom_range(0, 1023));
    s.red_light  = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    s.blue_light = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(0, 1023));
    if (mode == 9) begin
      if ($urandom_range(0, 1)) s.red_ratio = 10'd0;
      else s.blue_ratio = 10'd0;
    end
    return s;
  endfunction

  // Hold until the pipeline has drained, then write one register.
  task automatic write_typical(wbg_pkg::reg_idx_t idx, logic [9:0] value);
    while (pending_sets.size() != 0 || expected_gains.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [9:0] trg, logic [9:0] tbg, int count);
    write_typical(wbg_pkg::REG_TYPICAL_RG, trg);
    write_typical(wbg_pkg::REG_TYPICAL_BG, tbg);
    @(posedge clk);
    for (int i = 0; i < count; i++) pending_sets.push_back(random_set());
  endtask

  initial begin
    errors    = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = wbg_pkg::REG_TYPICAL_RG;
    cfg_data  = '0;
    typ_rg    = wbg_pkg::TYP_RG_RESET;
    typ_bg    = wbg_pkg::TYP_BG_RESET;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed sets against the reset typical ratios (312, 295).
    pending_sets.push_back(make_set(0, 0, 0, 0));         // all zero
    pending_sets.push_back(make_set(0, 295, 0, 0));       // zero R/G
    pending_sets.push_back(make_set(312, 0, 0, 0));       // zero B/G
    pending_sets.push_back(make_set(1, 295, 1, 0));       // adjusted R/G truncates to zero
    pending_sets.push_back(make_set(312, 1, 0, 1));       // adjusted B/G truncates to zero
    pending_sets.push_back(make_set(1023, 1023, 1023, 1023)); // all max
    pending_sets.push_back(make_set(1, 1, 0, 0));         // huge gains, saturate
    pending_sets.push_back(make_set(200, 200, 0, 0));     // both below typical
    pending_sets.push_back(make_set(400, 200, 0, 0));     // red high, blue low
    pending_sets.push_back(make_set(200, 400, 0, 0));     // red low, blue high
    pending_sets.push_back(make_set(624, 400, 0, 0));     // both high, red dominates
    pending_sets.push_back(make_set(400, 590, 0, 0));     // both high, blue dominates
    pending_sets.push_back(make_set(312, 295, 0, 0));     // exactly typical, tie
    pending_sets.push_back(make_set(624, 590, 0, 0));     // both double, tie
    pending_sets.push_back(make_set(300, 280, 512, 512)); // unity light factor
    pending_sets.push_back(make_set(300, 280, 1, 1));     // smallest light factor
    pending_sets.push_back(make_set(300, 280, 1023, 0));  // largest light factor, red only
    pending_sets.push_back(make_set(300, 280, 0, 1023));  // largest light factor, blue only
    pending_sets.push_back(make_set(1, 1023, 0, 0));      // extreme imbalance
    pending_sets.push_back(make_set(1023, 1, 0, 0));      // extreme imbalance, other side
    for (int i = 0; i < 60; i++) pending_sets.push_back(random_set());

    run_phase(10'd1, 10'd1, 50);
    run_phase(10'd1023, 10'd1023, 60);
    run_phase(10'd1023, 10'd1, 50);
    run_phase(10'd1, 10'd1023, 50);
    run_phase(10'd0, 10'd500, 20);   // typical R/G out of range: invalid
    run_phase(10'd500, 10'd0, 20);   // typical B/G out of range: invalid
    run_phase(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 60);
    run_phase(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)), 60);
    run_phase(wbg_pkg::TYP_RG_RESET, wbg_pkg::TYP_BG_RESET, 60);

    // Drain, then allow the pipeline depth for stray strobes.
    while (pending_sets.size() != 0 || expected_gains.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
